FILE: src/scfc_pkg.sv
`default_nettype none

package scfc_pkg;

    // Frame bytes beyond the payload: id (2), sequence (1), check (2)
    localparam int unsigned FRAME_OVERHEAD = 5;

    // Field widths
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned ID_W    = 16;
    localparam int unsigned SEQ_W   = 8;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USER_W  = 8;
    localparam int unsigned OUT_DATA_W = 80;

    // Register reset values
    localparam logic [ID_W-1:0]  CONN_ID_RST  = '0;
    localparam logic [CNT_W-1:0] WD_LIMIT_RST = 32'd1000;
    localparam logic [LEN_W-1:0] RX_CAP_RST   = 16'd64;
    localparam logic [LEN_W-1:0] TX_CAP_RST   = 16'd64;

    // Default depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_TICK  = 2'd1,
        OP_RESET = 2'd2,
        OP_BUILD = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_INIT   = 2'd0,
        ST_OK     = 2'd1,
        ST_FAILED = 2'd2
    } t_link;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LENGTH   = 3'd1,
        ERR_CHECK    = 3'd2,
        ERR_ID       = 3'd3,
        ERR_SEQUENCE = 3'd4,
        ERR_TIMEOUT  = 3'd5
    } t_err;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONN_ID  = 2'd0,
        CFG_WD_LIMIT = 2'd1,
        CFG_RX_CAP   = 2'd2,
        CFG_TX_CAP   = 2'd3
    } t_cfg_idx;

    // Classified request handed from front to back
    typedef struct packed {
        t_op              op;
        t_err             pre_err;   // first failing stateless check, or none
        logic [SEQ_W-1:0] fseq;
        logic [LEN_W-1:0] rx_plen;
        logic             build_ok;
        logic [LEN_W-1:0] built_len;
    } t_cmd;

endpackage

`default_nettype wire

FILE: src/scfc_front.sv
`default_nettype none

module scfc_front (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [scfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [scfc_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                  i_valid,
    input  wire                                  i_ready,
    input  wire  [scfc_pkg::IN_DATA_W-1:0]       i_data,
    input  wire  [scfc_pkg::IN_USER_W-1:0]       i_user,
    output logic                                 o_push,
    output scfc_pkg::t_cmd                       o_cmd,
    output logic [scfc_pkg::CNT_W-1:0]           o_wd_limit
);

    logic [scfc_pkg::ID_W-1:0]  r_conn_id;
    logic [scfc_pkg::CNT_W-1:0] r_wd_limit;
    logic [scfc_pkg::LEN_W-1:0] r_rx_cap;
    logic [scfc_pkg::LEN_W-1:0] r_tx_cap;

    logic [scfc_pkg::LEN_W-1:0] w_flen;
    logic [scfc_pkg::ID_W-1:0]  w_fid;
    logic [scfc_pkg::SEQ_W-1:0] w_fseq;
    logic                       w_match;
    logic [scfc_pkg::LEN_W-1:0] w_plen;
    logic [scfc_pkg::LEN_W:0]   w_rx_plen_x;
    logic [scfc_pkg::LEN_W:0]   w_build_len_x;
    logic                       w_len_ok;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn_id  <= scfc_pkg::CONN_ID_RST;
            r_wd_limit <= scfc_pkg::WD_LIMIT_RST;
            r_rx_cap   <= scfc_pkg::RX_CAP_RST;
            r_tx_cap   <= scfc_pkg::TX_CAP_RST;
        end else if (i_cfg_we) begin
            unique case (scfc_pkg::t_cfg_idx'(i_cfg_index))
                scfc_pkg::CFG_CONN_ID:  r_conn_id  <= i_cfg_data[scfc_pkg::ID_W-1:0];
                scfc_pkg::CFG_WD_LIMIT: r_wd_limit <= i_cfg_data;
                scfc_pkg::CFG_RX_CAP:   r_rx_cap   <= i_cfg_data[scfc_pkg::LEN_W-1:0];
                scfc_pkg::CFG_TX_CAP:   r_tx_cap   <= i_cfg_data[scfc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the request
    assign w_flen  = i_data[15:0];
    assign w_fid   = i_data[31:16];
    assign w_fseq  = i_data[39:32];
    assign w_match = i_data[40];
    assign w_plen  = i_data[56:41];

    // Length checks on both the receive and the build side
    assign w_rx_plen_x   = {1'b0, w_flen} - (scfc_pkg::LEN_W+1)'(scfc_pkg::FRAME_OVERHEAD);
    assign w_build_len_x = {1'b0, w_plen} + (scfc_pkg::LEN_W+1)'(scfc_pkg::FRAME_OVERHEAD);
    assign w_len_ok      = (w_flen > scfc_pkg::LEN_W'(scfc_pkg::FRAME_OVERHEAD))
                           && (w_rx_plen_x <= {1'b0, r_rx_cap});

    // Classify: resolve every check that does not depend on channel state
    always_comb begin
        o_cmd.op        = scfc_pkg::t_op'(i_user[1:0]);
        o_cmd.fseq      = w_fseq;
        o_cmd.rx_plen   = w_rx_plen_x[scfc_pkg::LEN_W-1:0];
        o_cmd.build_ok  = (w_plen != '0) && (w_build_len_x <= {1'b0, r_tx_cap});
        o_cmd.built_len = w_build_len_x[scfc_pkg::LEN_W-1:0];
        if (!w_len_ok) begin
            o_cmd.pre_err = scfc_pkg::ERR_LENGTH;
        end else if (!w_match) begin
            o_cmd.pre_err = scfc_pkg::ERR_CHECK;
        end else if (w_fid != r_conn_id) begin
            o_cmd.pre_err = scfc_pkg::ERR_ID;
        end else begin
            o_cmd.pre_err = scfc_pkg::ERR_NONE;
        end
    end

    assign o_push     = i_valid & i_ready;
    assign o_wd_limit = r_wd_limit;

endmodule

`default_nettype wire

FILE: src/scfc_queue.sv
`default_nettype none

module scfc_queue #(
    parameter int unsigned DEPTH = scfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire scfc_pkg::t_cmd  i_cmd,
    input  wire                  i_pop,
    output scfc_pkg::t_cmd       o_cmd,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    scfc_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/scfc_back.sv
`default_nettype none

module scfc_back (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire scfc_pkg::t_cmd                  i_cmd,
    input  wire                                  i_cmd_valid,
    output logic                                 o_pop,
    input  wire  [scfc_pkg::CNT_W-1:0]           i_wd_limit,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [scfc_pkg::OUT_DATA_W-1:0]      o_data
);

    // Channel state
    scfc_pkg::t_link            r_link,     n_link;
    scfc_pkg::t_err             r_err,      n_err;
    logic [scfc_pkg::CNT_W-1:0] r_fail_cnt, n_fail_cnt;
    logic [scfc_pkg::CNT_W-1:0] r_wd_cnt,   n_wd_cnt;
    logic [scfc_pkg::SEQ_W-1:0] r_rx_seq,   n_rx_seq;
    logic                       r_armed,    n_armed;
    logic [scfc_pkg::SEQ_W-1:0] r_tx_seq,   n_tx_seq;
    logic [scfc_pkg::LEN_W-1:0] r_good_len, n_good_len;

    // Result register
    logic                       r_out_valid;
    logic [scfc_pkg::OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                       w_acc;
    logic [scfc_pkg::SEQ_W-1:0] w_seq_used;
    logic [scfc_pkg::LEN_W-1:0] w_blen;
    logic                       w_fail;
    scfc_pkg::t_err             w_fail_code;
    logic [scfc_pkg::CNT_W-1:0] w_wd_inc;

    // Take the next request when the result register is free or draining
    assign o_pop    = i_cmd_valid & (~r_out_valid | i_ready);
    assign w_wd_inc = r_wd_cnt + 1'b1;

    // Carry out the request against the channel state
    always_comb begin
        n_link      = r_link;
        n_err       = r_err;
        n_fail_cnt  = r_fail_cnt;
        n_wd_cnt    = r_wd_cnt;
        n_rx_seq    = r_rx_seq;
        n_armed     = r_armed;
        n_tx_seq    = r_tx_seq;
        n_good_len  = r_good_len;
        w_acc       = 1'b0;
        w_seq_used  = '0;
        w_blen      = '0;
        w_fail      = 1'b0;
        w_fail_code = scfc_pkg::ERR_NONE;

        unique case (i_cmd.op)
            scfc_pkg::OP_CHECK: begin
                // Refuse silently while failed
                if (r_link != scfc_pkg::ST_FAILED) begin
                    if (i_cmd.pre_err != scfc_pkg::ERR_NONE) begin
                        w_fail      = 1'b1;
                        w_fail_code = i_cmd.pre_err;
                    end else if (r_armed && (i_cmd.fseq != r_rx_seq + 1'b1)) begin
                        w_fail      = 1'b1;
                        w_fail_code = scfc_pkg::ERR_SEQUENCE;
                    end else begin
                        w_acc      = 1'b1;
                        n_good_len = i_cmd.rx_plen;
                        n_rx_seq   = i_cmd.fseq;
                        n_armed    = 1'b1;
                        n_wd_cnt   = '0;
                        n_link     = scfc_pkg::ST_OK;
                        n_err      = scfc_pkg::ERR_NONE;
                    end
                end
            end
            scfc_pkg::OP_TICK: begin
                // Count toward the limit and stop there
                if (r_wd_cnt < i_wd_limit) begin
                    n_wd_cnt = w_wd_inc;
                    if (w_wd_inc >= i_wd_limit) begin
                        w_fail      = 1'b1;
                        w_fail_code = scfc_pkg::ERR_TIMEOUT;
                    end
                end
            end
            scfc_pkg::OP_RESET: begin
                n_link     = scfc_pkg::ST_INIT;
                n_err      = scfc_pkg::ERR_NONE;
                n_wd_cnt   = '0;
                n_armed    = 1'b0;
                n_good_len = '0;
            end
            scfc_pkg::OP_BUILD: begin
                if (i_cmd.build_ok) begin
                    w_acc      = 1'b1;
                    w_seq_used = r_tx_seq;
                    w_blen     = i_cmd.built_len;
                    n_tx_seq   = r_tx_seq + 1'b1;
                end
            end
            default: ;
        endcase

        // Fail the channel and bump the saturating error count
        if (w_fail) begin
            n_link = scfc_pkg::ST_FAILED;
            n_err  = w_fail_code;
            if (r_fail_cnt != '1) begin
                n_fail_cnt = r_fail_cnt + 1'b1;
            end
        end

        n_out_data = {2'b00, n_good_len, n_fail_cnt, n_err, n_link, w_blen, w_seq_used,
                      w_acc};
    end

    // Update state on each taken request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link     <= scfc_pkg::ST_INIT;
            r_err      <= scfc_pkg::ERR_NONE;
            r_fail_cnt <= '0;
            r_wd_cnt   <= '0;
            r_rx_seq   <= '0;
            r_armed    <= 1'b0;
            r_tx_seq   <= '0;
            r_good_len <= '0;
        end else if (o_pop) begin
            r_link     <= n_link;
            r_err      <= n_err;
            r_fail_cnt <= n_fail_cnt;
            r_wd_cnt   <= n_wd_cnt;
            r_rx_seq   <= n_rx_seq;
            r_armed    <= n_armed;
            r_tx_seq   <= n_tx_seq;
            r_good_len <= n_good_len;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

`default_nettype wire

FILE: src/safety_channel_frame_checker_core.sv
`default_nettype none

// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   one event request
// m_axis    out  m_axis_tvalid/m_axis_tready   one result per request
// cfg       in   i_cfg_we (no wait)            register index and data
//
// One request per cycle sustained while m_axis_tready is high; the front
// classifies a taken request into the queue at the accepting edge, and the
// back, when the result register is free or draining, updates state and
// loads that register. The back part holds the whole channel state, so each
// request resolves there. A stalled output fills the command queue, then
// drops s_axis_tready. Reset is synchronous, active low, and clears the state,
// the queue, the output valid and the configuration registers at once.

module safety_channel_frame_checker_core #(
    parameter int unsigned QUEUE_DEPTH = scfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration
    input  wire                                  i_cfg_we,
    input  wire  [scfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [scfc_pkg::CFG_W-1:0]           i_cfg_data,
    // Requests
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // frame_length[15:0], frame_id[31:16], frame_sequence[39:32],
    // check_matches[40], payload_length[56:41], zero fill [63:57]
    input  wire  [scfc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // opcode[1:0], zero fill [7:2]
    input  wire  [scfc_pkg::IN_USER_W-1:0]       s_axis_tuser,
    // Results
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // accepted[0], tx_sequence_used[8:1], built_length[24:9],
    // channel_state[26:25], last_error[29:27], error_total[61:30],
    // stored_payload_length[77:62], zero fill [79:78]
    output logic [scfc_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    logic                       w_push;
    logic                       w_pop;
    logic                       w_q_empty;
    logic                       w_q_full;
    scfc_pkg::t_cmd             w_cmd_in;
    scfc_pkg::t_cmd             w_cmd_out;
    logic [scfc_pkg::CNT_W-1:0] w_wd_limit;
    logic [scfc_pkg::OUT_DATA_W-1:0] w_res;

    assign s_axis_tready = ~w_q_full;

    scfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in),
        .o_wd_limit  (w_wd_limit)
    );

    scfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    scfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (~w_q_empty),
        .o_pop       (w_pop),
        .i_wd_limit  (w_wd_limit),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_res)
    );

    assign m_axis_tdata = w_res;

endmodule

`default_nettype wire
